// ===== rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin thread scheduler.
package rrts_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned SLOT_FIELD_W   = 4;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE      = 3'd0,
    REQ_YIELD       = 3'd1,
    REQ_EXIT        = 3'd2,
    REQ_WAIT        = 3'd3,
    REQ_NOTIFY      = 3'd4,
    REQ_NOTIFY_ALL  = 3'd5,
    REQ_START       = 3'd6,
    REQ_MAIN_RETURN = 3'd7
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_READY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CLAIM,
    CELL_FREE,
    CELL_SLEEP,
    CELL_NOTIFY,
    CELL_NOTIFY_ALL
  } cell_op_e;

  typedef enum logic {
    SCAN_FREE,
    SCAN_READY
  } scan_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    scan_mode_e       mode;
    logic             tok_load;
    logic             tok_shift;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

// ===== rtl/rrts_cell.sv =====
// One thread slot: in-use, ready and wait-key state plus a scan token stage.
module rrts_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrts_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  logic               tok_i,
  output logic               tok_o,
  output logic               hit_o
);

  logic                       in_use_q, in_use_d;
  logic                       ready_q, ready_d;
  logic [rrts_pkg::KEY_W-1:0] key_q, key_d;
  logic                       tok_q, tok_d;
  logic                       key_match;

  assign key_match = (key_q == cmd_i.key);

  always_comb begin
    in_use_d = in_use_q;
    ready_d  = ready_q;
    key_d    = key_q;
    case (cmd_i.op)
      rrts_pkg::CELL_CLAIM: begin
        if (sel_i) begin
          in_use_d = 1'b1;
          ready_d  = 1'b1;
        end
      end
      rrts_pkg::CELL_FREE: begin
        if (sel_i) begin
          in_use_d = 1'b0;
        end
      end
      rrts_pkg::CELL_SLEEP: begin
        if (sel_i) begin
          ready_d = 1'b0;
          key_d   = cmd_i.key;
        end
      end
      rrts_pkg::CELL_NOTIFY: begin
        if (sel_i && key_match) begin
          ready_d = 1'b1;
        end
      end
      rrts_pkg::CELL_NOTIFY_ALL: begin
        if (key_match) begin
          ready_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tok_d = tok_q;
    if (cmd_i.tok_load) begin
      tok_d = sel_i;
    end else if (cmd_i.tok_shift) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      ready_q  <= 1'b0;
      key_q    <= '0;
      tok_q    <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      ready_q  <= ready_d;
      key_q    <= key_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign hit_o = tok_q & ((cmd_i.mode == rrts_pkg::SCAN_FREE) ? !in_use_q
                                                             : (in_use_q & ready_q));

endmodule

// ===== rtl/round_robin_thread_scheduler_top.sv =====
// Round-robin thread scheduler: sequencer over a ring of slot cells.
// Notify, notify-all and main-return pass through modify and finish; create, yield,
// exit, wait and start also load and scan, the scan token stepping one cell per cycle
// around the ring. One item in flight; the next is taken once
// the result sits in the output register. Reset (async, active low) clears all
// slots, keys, current/main thread and the output valid.
module round_robin_thread_scheduler_top #(
  parameter int unsigned SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rrts_pkg::REQ_W-1:0]          req_type_i,
  input  logic [rrts_pkg::KEY_W-1:0]          wait_key_i,
  input  logic [rrts_pkg::SLOT_FIELD_W-1:0]   target_slot_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rrts_pkg::STATUS_W-1:0]       status_o,
  output logic [rrts_pkg::SLOT_FIELD_W-1:0]   result_slot_o,
  output logic                                switch_now_o,
  output logic [rrts_pkg::SLOT_FIELD_W-1:0]   previous_slot_o,
  output logic                                running_valid_o,
  output logic [rrts_pkg::SLOT_FIELD_W-1:0]   running_slot_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  rrts_pkg::state_e  state_q, state_d;
  rrts_pkg::req_e    req_q, req_d;
  logic [rrts_pkg::KEY_W-1:0]        key_q, key_d;
  logic [rrts_pkg::SLOT_FIELD_W-1:0] tgt_q, tgt_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic              cur_valid_q, cur_valid_d;
  logic [SW-1:0]     cur_q, cur_d;
  logic              main_valid_q, main_valid_d;
  logic [SW-1:0]     main_q, main_d;
  logic [SW-1:0]     pos_q, pos_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  rrts_pkg::status_e res_status_q, res_status_d;
  logic [SW-1:0]     res_slot_q, res_slot_d;
  logic              res_sw_q, res_sw_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  rrts_pkg::cell_cmd_t cmd;
  logic [SLOT_COUNT-1:0] sel;
  logic [SLOT_COUNT-1:0] tok_vec;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic                  hit;
  logic                  scan_req;
  logic [SW-1:0]         start_idx;
  logic [SW-1:0]         sel_idx;
  logic                  sel_en;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    rrts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .sel_i  (sel[g]),
      .tok_i  (tok_vec[(g + SLOT_COUNT - 1) % SLOT_COUNT]),
      .tok_o  (tok_vec[g]),
      .hit_o  (hit_vec[g])
    );
  end

  assign hit      = |hit_vec;
  assign scan_req = req_q inside {rrts_pkg::REQ_CREATE, rrts_pkg::REQ_YIELD,
                                  rrts_pkg::REQ_EXIT, rrts_pkg::REQ_WAIT,
                                  rrts_pkg::REQ_START};
  assign start_idx = (req_q == rrts_pkg::REQ_CREATE || req_q == rrts_pkg::REQ_START
                      || !cur_valid_q) ? '0
                   : ((cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1);
  assign out_load  = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sel[i] = sel_en && (sel_idx == SW'(i));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rrts_pkg::ST_MODIFY;
        end
      end
      rrts_pkg::ST_MODIFY: begin
        state_d = scan_req ? rrts_pkg::ST_LOAD : rrts_pkg::ST_FINISH;
      end
      rrts_pkg::ST_LOAD: begin
        state_d = rrts_pkg::ST_SCAN;
      end
      rrts_pkg::ST_SCAN: begin
        if (hit || cnt_q == LAST_SLOT) begin
          state_d = rrts_pkg::ST_FINISH;
        end
      end
      rrts_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = rrts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd.op        = rrts_pkg::CELL_NOP;
    cmd.mode      = (req_q == rrts_pkg::REQ_CREATE) ? rrts_pkg::SCAN_FREE
                                                    : rrts_pkg::SCAN_READY;
    cmd.tok_load  = 1'b0;
    cmd.tok_shift = 1'b0;
    cmd.key       = key_q;
    sel_en        = 1'b0;
    sel_idx       = '0;
    req_d         = req_q;
    key_d         = key_q;
    tgt_d         = tgt_q;
    prev_d        = prev_q;
    cur_valid_d   = cur_valid_q;
    cur_d         = cur_q;
    main_valid_d  = main_valid_q;
    main_d        = main_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    res_status_d  = res_status_q;
    res_slot_d    = res_slot_q;
    res_sw_d      = res_sw_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;

    case (state_q)
      rrts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d  = rrts_pkg::req_e'(req_type_i);
          key_d  = wait_key_i;
          tgt_d  = target_slot_i;
          prev_d = cur_valid_q ? cur_q : '0;
        end
      end
      rrts_pkg::ST_MODIFY: begin
        res_status_d = rrts_pkg::STATUS_DONE;
        res_slot_d   = '0;
        res_sw_d     = 1'b0;
        case (req_q)
          rrts_pkg::REQ_EXIT: begin
            cmd.op  = rrts_pkg::CELL_FREE;
            sel_en  = cur_valid_q;
            sel_idx = cur_q;
          end
          rrts_pkg::REQ_WAIT: begin
            cmd.op  = rrts_pkg::CELL_SLEEP;
            sel_en  = cur_valid_q;
            sel_idx = cur_q;
          end
          rrts_pkg::REQ_NOTIFY: begin
            cmd.op  = rrts_pkg::CELL_NOTIFY;
            sel_en  = (32'(tgt_q) < SLOT_COUNT);
            sel_idx = SW'(tgt_q);
          end
          rrts_pkg::REQ_NOTIFY_ALL: begin
            cmd.op = rrts_pkg::CELL_NOTIFY_ALL;
          end
          rrts_pkg::REQ_MAIN_RETURN: begin
            cmd.op      = rrts_pkg::CELL_FREE;
            sel_en      = main_valid_q;
            sel_idx     = main_q;
            cur_valid_d = 1'b0;
            cur_d       = '0;
          end
          default: begin
          end
        endcase
      end
      rrts_pkg::ST_LOAD: begin
        cmd.tok_load = 1'b1;
        sel_en       = 1'b1;
        sel_idx      = start_idx;
        pos_d        = start_idx;
        cnt_d        = '0;
      end
      rrts_pkg::ST_SCAN: begin
        if (hit) begin
          res_slot_d = pos_q;
          if (req_q == rrts_pkg::REQ_CREATE) begin
            cmd.op  = rrts_pkg::CELL_CLAIM;
            sel_en  = 1'b1;
            sel_idx = pos_q;
          end else begin
            res_sw_d    = 1'b1;
            cur_valid_d = 1'b1;
            cur_d       = pos_q;
            if (req_q == rrts_pkg::REQ_START) begin
              main_valid_d = 1'b1;
              main_d       = pos_q;
            end
          end
        end else if (cnt_q == LAST_SLOT) begin
          if (req_q == rrts_pkg::REQ_CREATE) begin
            res_status_d = rrts_pkg::STATUS_FULL;
          end else if (req_q == rrts_pkg::REQ_START) begin
            res_status_d = rrts_pkg::STATUS_NO_READY;
          end else if (main_valid_q) begin
            res_sw_d    = 1'b1;
            res_slot_d  = main_q;
            cur_valid_d = 1'b1;
            cur_d       = main_q;
          end else begin
            cur_valid_d = 1'b0;
            cur_d       = '0;
          end
        end else begin
          cmd.tok_shift = 1'b1;
          pos_d         = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
      end
      rrts_pkg::ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrts_pkg::ST_IDLE;
      cur_valid_q  <= 1'b0;
      cur_q        <= '0;
      main_valid_q <= 1'b0;
      main_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_valid_q  <= cur_valid_d;
      cur_q        <= cur_d;
      main_valid_q <= main_valid_d;
      main_q       <= main_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    tgt_q        <= tgt_d;
    prev_q       <= prev_d;
    pos_q        <= pos_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_sw_q     <= res_sw_d;
    if (state_q == rrts_pkg::ST_FINISH && out_load) begin
      status_o        <= res_status_q;
      result_slot_o   <= rrts_pkg::SLOT_FIELD_W'(res_slot_q);
      switch_now_o    <= res_sw_q;
      previous_slot_o <= rrts_pkg::SLOT_FIELD_W'(prev_q);
      running_valid_o <= cur_valid_q;
      running_slot_o  <= cur_valid_q ? rrts_pkg::SLOT_FIELD_W'(cur_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_token_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the ring");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken while one is in progress");

  a_switch_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switch_now_o |-> running_valid_o && running_slot_o == result_slot_o)
    else $error("switch target differs from running slot");

endmodule

// ===== dv/tb_round_robin_thread_scheduler_top.sv =====
// Testbench for the round-robin thread scheduler: directed and random requests with checking.
`timescale 1ns / 100ps

module tb_round_robin_thread_scheduler_top;

  localparam int unsigned SLOTS = rrts_pkg::SLOT_COUNT_DEF;
  // Limit covers the slowest item plus long random gaps on both sides.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    rrts_pkg::status_e                 status;
    logic [rrts_pkg::SLOT_FIELD_W-1:0] result_slot;
    logic                              switch_now;
    logic [rrts_pkg::SLOT_FIELD_W-1:0] previous_slot;
    logic                              running_valid;
    logic [rrts_pkg::SLOT_FIELD_W-1:0] running_slot;
  } sched_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [rrts_pkg::REQ_W-1:0]        req_type_i = '0;
  logic [rrts_pkg::KEY_W-1:0]        wait_key_i = '0;
  logic [rrts_pkg::SLOT_FIELD_W-1:0] target_slot_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [rrts_pkg::STATUS_W-1:0]     status_o;
  logic [rrts_pkg::SLOT_FIELD_W-1:0] result_slot_o;
  logic                              switch_now_o;
  logic [rrts_pkg::SLOT_FIELD_W-1:0] previous_slot_o;
  logic                              running_valid_o;
  logic [rrts_pkg::SLOT_FIELD_W-1:0] running_slot_o;

  // Scheduler shadow state
  logic                       thr_in_use [SLOTS];
  logic                       thr_ready  [SLOTS];
  logic [rrts_pkg::KEY_W-1:0] thr_key    [SLOTS];
  logic [3:0]                 cur_slot;
  logic                       cur_valid;
  logic [3:0]                 main_slot;
  logic                       main_valid;

  sched_result_t              pending_results[$];
  logic [rrts_pkg::KEY_W-1:0] key_pool[8];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned req_cnt       = 0;
  int unsigned result_cnt    = 0;
  int unsigned switch_cnt    = 0;
  int unsigned full_cnt      = 0;
  int unsigned no_ready_cnt  = 0;

  round_robin_thread_scheduler_top #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .wait_key_i     (wait_key_i),
    .target_slot_i  (target_slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_slot_o  (result_slot_o),
    .switch_now_o   (switch_now_o),
    .previous_slot_o(previous_slot_o),
    .running_valid_o(running_valid_o),
    .running_slot_o (running_slot_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_sched_state();
    for (int i = 0; i < SLOTS; i++) begin
      thr_in_use[i] = 1'b0;
      thr_ready[i]  = 1'b0;
      thr_key[i]    = '0;
    end
    cur_slot   = '0;
    cur_valid  = 1'b0;
    main_slot  = '0;
    main_valid = 1'b0;
  endfunction

  // Round-robin pick after the current thread, falling back to main.
  function automatic logic rr_switch(output logic [3:0] to_slot);
    int unsigned first;
    int unsigned idx;
    first = cur_valid ? int'(cur_slot) + 1 : 0;
    for (int i = 0; i < SLOTS; i++) begin
      idx = (first + i) % SLOTS;
      if (thr_in_use[idx] && thr_ready[idx]) begin
        cur_slot  = 4'(idx);
        cur_valid = 1'b1;
        to_slot   = 4'(idx);
        return 1'b1;
      end
    end
    if (main_valid) begin
      cur_slot  = 4'(int'(main_slot) % SLOTS);
      cur_valid = 1'b1;
      to_slot   = cur_slot;
      return 1'b1;
    end
    cur_slot  = '0;
    cur_valid = 1'b0;
    to_slot   = '0;
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_request(rrts_pkg::req_e req,
                                                     logic [rrts_pkg::KEY_W-1:0] key,
                                                     logic [3:0] tgt);
    sched_result_t r;
    logic [3:0]    to_slot;
    r.status        = rrts_pkg::STATUS_DONE;
    r.result_slot   = '0;
    r.switch_now    = 1'b0;
    r.previous_slot = cur_valid ? cur_slot : '0;
    to_slot         = '0;
    case (req)
      rrts_pkg::REQ_CREATE: begin
        r.status = rrts_pkg::STATUS_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!thr_in_use[i]) begin
            thr_in_use[i] = 1'b1;
            thr_ready[i]  = 1'b1;
            r.status      = rrts_pkg::STATUS_DONE;
            r.result_slot = 4'(i);
            break;
          end
        end
      end
      rrts_pkg::REQ_YIELD: begin
        r.switch_now  = rr_switch(to_slot);
        r.result_slot = to_slot;
      end
      rrts_pkg::REQ_EXIT: begin
        if (cur_valid) thr_in_use[cur_slot] = 1'b0;
        r.switch_now  = rr_switch(to_slot);
        r.result_slot = to_slot;
      end
      rrts_pkg::REQ_WAIT: begin
        if (cur_valid) begin
          thr_ready[cur_slot] = 1'b0;
          thr_key[cur_slot]   = key;
        end
        r.switch_now  = rr_switch(to_slot);
        r.result_slot = to_slot;
      end
      rrts_pkg::REQ_NOTIFY: begin
        if (int'(tgt) < SLOTS && thr_key[tgt] == key) thr_ready[tgt] = 1'b1;
      end
      rrts_pkg::REQ_NOTIFY_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (thr_key[i] == key) thr_ready[i] = 1'b1;
        end
      end
      rrts_pkg::REQ_START: begin
        r.status = rrts_pkg::STATUS_NO_READY;
        for (int i = 0; i < SLOTS; i++) begin
          if (thr_in_use[i] && thr_ready[i]) begin
            cur_slot      = 4'(i);
            cur_valid     = 1'b1;
            main_slot     = 4'(i);
            main_valid    = 1'b1;
            r.status      = rrts_pkg::STATUS_DONE;
            r.result_slot = 4'(i);
            r.switch_now  = 1'b1;
            break;
          end
        end
      end
      default: begin
        if (main_valid) thr_in_use[main_slot] = 1'b0;
        cur_valid = 1'b0;
        cur_slot  = '0;
      end
    endcase
    r.running_valid = cur_valid;
    r.running_slot  = cur_valid ? cur_slot : '0;
    return r;
  endfunction

  task automatic send_req(input rrts_pkg::req_e req, input logic [rrts_pkg::KEY_W-1:0] key,
                          input logic [3:0] tgt);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    wait_key_i    <= key;
    target_slot_i <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(schedule_request(req, key, tgt));
    req_cnt++;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] seen);
    if (want !== seen) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("Mismatch on result %0d, %s: expected %0d, got %0d", result_cnt, name, want,
                 seen);
    end
  endtask

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 4'(want.status), 4'(status_o));
        check_field("result_slot", want.result_slot, result_slot_o);
        check_field("switch_now", 4'(want.switch_now), 4'(switch_now_o));
        check_field("previous_slot", want.previous_slot, previous_slot_o);
        check_field("running_valid", 4'(want.running_valid), 4'(running_valid_o));
        check_field("running_slot", want.running_slot, running_slot_o);
        if (want.switch_now) switch_cnt++;
        if (want.status == rrts_pkg::STATUS_FULL) full_cnt++;
        if (want.status == rrts_pkg::STATUS_NO_READY) no_ready_cnt++;
      end
      result_cnt++;
    end
    out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Everything empty: no thread to start, run or free.
  task automatic test_empty_table();
    send_req(rrts_pkg::REQ_START, '0, '0);
    send_req(rrts_pkg::REQ_YIELD, '0, '0);
    send_req(rrts_pkg::REQ_EXIT, '0, 4'hf);
    send_req(rrts_pkg::REQ_WAIT, '1, '0);
    send_req(rrts_pkg::REQ_MAIN_RETURN, '0, '0);
    send_req(rrts_pkg::REQ_NOTIFY, '1, 4'hf);
    // key 0 matches every unused slot
    send_req(rrts_pkg::REQ_NOTIFY_ALL, '0, '0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= SLOTS; i++)
      send_req(rrts_pkg::REQ_CREATE, {$urandom, $urandom}, 4'($urandom));
  endtask

  task automatic test_switching();
    send_req(rrts_pkg::REQ_START, '0, '0);
    send_req(rrts_pkg::REQ_YIELD, '0, '0);
    send_req(rrts_pkg::REQ_WAIT, '1, '0);
    send_req(rrts_pkg::REQ_NOTIFY, '0, 4'd1);
    send_req(rrts_pkg::REQ_NOTIFY, '1, 4'd1);
    send_req(rrts_pkg::REQ_EXIT, '0, '0);
    send_req(rrts_pkg::REQ_NOTIFY_ALL, '1, '0);
    send_req(rrts_pkg::REQ_MAIN_RETURN, '0, '0);
    send_req(rrts_pkg::REQ_YIELD, '0, '0);
  endtask

  function automatic logic [rrts_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(9, 0) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(7, 0)];
  endfunction

  task automatic test_random_traffic(input int n_items, input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
    int unsigned                pick;
    rrts_pkg::req_e             req;
    logic [rrts_pkg::KEY_W-1:0] key;
    logic [3:0]                 tgt;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)      req = rrts_pkg::REQ_CREATE;
      else if (pick < 38) req = rrts_pkg::REQ_YIELD;
      else if (pick < 52) req = rrts_pkg::REQ_EXIT;
      else if (pick < 66) req = rrts_pkg::REQ_WAIT;
      else if (pick < 78) req = rrts_pkg::REQ_NOTIFY;
      else if (pick < 86) req = rrts_pkg::REQ_NOTIFY_ALL;
      else if (pick < 94) req = rrts_pkg::REQ_START;
      else                req = rrts_pkg::REQ_MAIN_RETURN;
      tgt = 4'($urandom_range(15, 0));
      key = {$urandom, $urandom};
      case (req)
        rrts_pkg::REQ_WAIT:   key = pick_key();
        rrts_pkg::REQ_NOTIFY: key = $urandom_range(1, 0) ? thr_key[tgt] : pick_key();
        rrts_pkg::REQ_NOTIFY_ALL:
          key = $urandom_range(1, 0) ? thr_key[$urandom_range(SLOTS - 1, 0)] : pick_key();
        default: ;
      endcase
      send_req(req, key, tgt);
    end
  endtask

  initial begin
    clear_sched_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_table_full();
    test_switching();
    test_random_traffic(270, 38, 83);
    test_random_traffic(270, 83, 38);
    test_random_traffic(270, 0, 0);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    $display("Ran %0d requests (directed then random under three idle mixes), %0d results",
             req_cnt, result_cnt);
    $display("  %0d switches, %0d full-table creates, %0d starts with nothing ready",
             switch_cnt, full_cnt, no_ready_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== round_robin_thread_scheduler_top.f =====
rtl/rrts_pkg.sv
rtl/rrts_cell.sv
rtl/round_robin_thread_scheduler_top.sv
dv/tb_round_robin_thread_scheduler_top.sv
